>>> hdl/klerp_pkg.sv
// ----------------------------------------------------------------------------
// klerp_pkg
// Shared types and constants for the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package klerp_pkg;

    localparam int KEYS_DEF    = 16;
    localparam int VALUE_W_DEF = 24;
    localparam int TIME_W_DEF  = 24;

    localparam int SLOT_W  = 4;
    localparam int SEG_W   = 4;
    localparam int COUNT_W = 5;
    localparam int FRAC_W  = 16;
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } klerp_div_stat_t;

endpackage

>>> hdl/keyframe_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_top
// Keyframe track interpolator: key table writes and linear queries.
// ----------------------------------------------------------------------------
// A write transaction (tuser 0) stores a key and returns nothing. A query
// transaction (tuser 1) returns one result; the scan reads one key time at a
// time through the single table read port, the factor comes from a 16-step
// serial divider, and the three components go one after another through one
// shared multiplier. A single key or a time at or past the last key skips the
// divider. The input is not ready while a query is in progress; a finished
// result waits in the output register while the next transaction is taken.
// The user must write key_count only while the block is idle; the block
// itself does not enforce it.
module keyframe_linear_interpolator_top
    import klerp_pkg::*;
#(
    parameter int MAX_KEYS    = KEYS_DEF,
    parameter int VALUE_WIDTH = VALUE_W_DEF,
    parameter int TIME_WIDTH  = TIME_W_DEF,
    localparam int IN_W       = SLOT_W + 2*TIME_WIDTH + 3*VALUE_WIDTH,
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W      = 3*VALUE_WIDTH + SEG_W,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   key_count_we,
    input  logic [COUNT_W-1:0]     key_count_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // key_slot, key_time, key_x, key_y, key_z, query_time, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_x, out_y, out_z, segment_index, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int VW = VALUE_WIDTH;
    localparam int TW = TIME_WIDTH;
    localparam int PW = VW + FRAC_W + 2;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_SRCH_RD  = 12'b0000_0000_0010,
        S_SRCH_CMP = 12'b0000_0000_0100,
        S_T1_RD    = 12'b0000_0000_1000,
        S_T1_CMP   = 12'b0000_0001_0000,
        S_DIV_WAIT = 12'b0000_0010_0000,
        S_VS_RD    = 12'b0000_0100_0000,
        S_VE_RD    = 12'b0000_1000_0000,
        S_VE_CAP   = 12'b0001_0000_0000,
        S_MUL      = 12'b0010_0000_0000,
        S_ACC      = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]   key_count_reg;
    logic [CW-1:0]        n_reg;
    logic [TW-1:0]        q_reg;
    logic [AW-1:0]        idx_reg;
    logic [TW-1:0]        t2_reg;
    logic [AW-1:0]        s_idx_reg;
    logic [AW-1:0]        e_idx_reg;
    logic [SEG_W-1:0]     seg_reg;
    logic [FRAC_W-1:0]    f_reg;
    logic [3*VW-1:0]      s_val_reg;
    logic [3*VW-1:0]      e_val_reg;
    logic [1:0]           comp_reg;
    logic signed [PW-1:0] prod_reg;
    logic [3*VW-1:0]      res_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic                 m_valid_reg;

    logic                 in_acc;
    logic                 is_query;
    logic                 wr_en;
    logic [CW-1:0]        n_eff;
    logic [AW-1:0]        rd_addr;
    logic [TW-1:0]        rd_time;
    logic [3*VW-1:0]      rd_val;
    logic                 search_hit;
    logic                 search_end;
    logic                 degenerate;
    logic                 div_start;
    klerp_div_stat_t      div_stat;
    logic [FRAC_W-1:0]    div_quot;
    logic                 load_out;

    logic [VW-1:0]        s_c;
    logic [VW-1:0]        e_c;
    logic signed [VW:0]   d_w;
    logic signed [FRAC_W:0] f_w;
    logic signed [PW-1:0] prod_w;
    logic signed [PW-1:0] rnd_w;
    logic signed [PW-1:0] shift_w;
    logic [VW-1:0]        res_c;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign is_query = (s_tuser == REQ_QUERY);
    assign wr_en    = in_acc && (s_tuser == REQ_WRITE) && (32'(s_tdata[SLOT_W-1:0]) < MAX_KEYS);

    always_comb
    begin
        if (key_count_reg == '0)
            n_eff = CW'(1);
        else if (32'(key_count_reg) > MAX_KEYS)
            n_eff = CW'(MAX_KEYS);
        else
            n_eff = CW'(key_count_reg);
    end

    assign search_hit = q_reg < rd_time;
    assign search_end = (32'(idx_reg) + 2) >= 32'(n_reg);
    assign degenerate = (t2_reg <= rd_time) || (q_reg <= rd_time);
    assign div_start  = (state_reg == S_T1_CMP) && !degenerate;
    assign load_out   = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    always_comb
    begin
        unique case (state_reg)
            S_SRCH_RD: rd_addr = AW'(32'(idx_reg) + 1);
            S_T1_RD:   rd_addr = idx_reg;
            S_VS_RD:   rd_addr = s_idx_reg;
            S_VE_RD:   rd_addr = e_idx_reg;
            default:   rd_addr = '0;
        endcase
    end

    klerp_store #(
        .MAX_KEYS    (MAX_KEYS),
        .TIME_WIDTH  (TW),
        .VALUE_WIDTH (VW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_tdata[SLOT_W-1:0])),
        .wr_time (s_tdata[SLOT_W +: TW]),
        .wr_val  (s_tdata[SLOT_W+TW +: 3*VW]),
        .rd_addr (rd_addr),
        .rd_time (rd_time),
        .rd_val  (rd_val)
    );

    klerp_div #(
        .TIME_WIDTH (TW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (q_reg - rd_time),
        .den   (t2_reg - rd_time),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && is_query)
                    state_next = (n_eff == CW'(1)) ? S_VS_RD : S_SRCH_RD;
            end
            S_SRCH_RD:  state_next = S_SRCH_CMP;
            S_SRCH_CMP:
            begin
                if (search_hit)
                    state_next = S_T1_RD;
                else if (search_end)
                    state_next = S_VS_RD;
                else
                    state_next = S_SRCH_RD;
            end
            S_T1_RD:    state_next = S_T1_CMP;
            S_T1_CMP:   state_next = degenerate ? S_VS_RD : S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                    state_next = S_VS_RD;
            end
            S_VS_RD:    state_next = S_VE_RD;
            S_VE_RD:    state_next = S_VE_CAP;
            S_VE_CAP:   state_next = S_MUL;
            S_MUL:      state_next = S_ACC;
            S_ACC:      state_next = (comp_reg == 2'd2) ? S_DONE : S_MUL;
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_count_reg <= COUNT_W'(1);
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (key_count_we)
                key_count_reg <= key_count_wdata;
            if (load_out)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    assign s_c    = s_val_reg[comp_reg*VW +: VW];
    assign e_c    = e_val_reg[comp_reg*VW +: VW];
    assign d_w    = $signed({e_c[VW-1], e_c}) - $signed({s_c[VW-1], s_c});
    assign f_w    = $signed({1'b0, f_reg});
    assign prod_w = d_w * f_w;
    assign rnd_w  = prod_reg + PW'(ROUND_HALF);
    assign shift_w = rnd_w >>> FRAC_W;
    assign res_c  = s_c + shift_w[VW-1:0];

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && is_query)
                begin
                    q_reg     <= s_tdata[SLOT_W+TW+3*VW +: TW];
                    n_reg     <= n_eff;
                    idx_reg   <= '0;
                    s_idx_reg <= '0;
                    e_idx_reg <= '0;
                    f_reg     <= '0;
                    seg_reg   <= '0;
                end
            end
            S_SRCH_CMP:
            begin
                if (search_hit)
                    t2_reg <= rd_time;
                else
                begin
                    idx_reg   <= AW'(32'(idx_reg) + 1);
                    s_idx_reg <= AW'(32'(n_reg) - 1);
                    e_idx_reg <= AW'(32'(n_reg) - 1);
                    f_reg     <= '0;
                    seg_reg   <= SEG_W'(32'(n_reg) - 2);
                end
            end
            S_T1_CMP:
            begin
                s_idx_reg <= idx_reg;
                e_idx_reg <= AW'(32'(idx_reg) + 1);
                seg_reg   <= SEG_W'(idx_reg);
                f_reg     <= '0;
            end
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                    f_reg <= div_quot;
            end
            S_VE_RD:
            begin
                s_val_reg <= rd_val;
            end
            S_VE_CAP:
            begin
                e_val_reg <= rd_val;
                comp_reg  <= '0;
            end
            S_MUL:
            begin
                prod_reg <= prod_w;
            end
            S_ACC:
            begin
                res_reg[comp_reg*VW +: VW] <= res_c;
                comp_reg <= comp_reg + 2'd1;
            end
            S_DONE:
            begin
                if (load_out)
                    m_data_reg <= OUT_TDATA_W'({seg_reg, res_reg});
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_query_holds_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && is_query |=> !s_tready)
        else $error("input ready right after a query transaction");

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy || div_stat.done |-> state_reg == S_DIV_WAIT)
        else $error("divider active outside its wait state");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SRCH_RD |-> (32'(idx_reg) + 1) < 32'(n_reg))
        else $error("key scan past the last valid key");

    a_comp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL || state_reg == S_ACC |-> comp_reg != 2'd3)
        else $error("component counter out of range");

endmodule

>>> hdl/klerp_store.sv
// ----------------------------------------------------------------------------
// klerp_store
// Key table: time and packed 3-vector value per slot, one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module klerp_store
    import klerp_pkg::*;
#(
    parameter int MAX_KEYS    = KEYS_DEF,
    parameter int TIME_WIDTH  = TIME_W_DEF,
    parameter int VALUE_WIDTH = VALUE_W_DEF,
    localparam int AW = $clog2(MAX_KEYS)
)
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [TIME_WIDTH-1:0]      wr_time,
    input  logic [3*VALUE_WIDTH-1:0]   wr_val,
    input  logic [AW-1:0]              rd_addr,
    output logic [TIME_WIDTH-1:0]      rd_time,
    output logic [3*VALUE_WIDTH-1:0]   rd_val
);

    logic [TIME_WIDTH-1:0]    time_mem [MAX_KEYS];
    logic [3*VALUE_WIDTH-1:0] val_mem  [MAX_KEYS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_addr] <= wr_time;
            val_mem[wr_addr]  <= wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_time <= time_mem[rd_addr];
        rd_val  <= val_mem[rd_addr];
    end

endmodule

>>> hdl/klerp_div.sv
// ----------------------------------------------------------------------------
// klerp_div
// Restoring divider for the interpolation factor: (num << FRAC_W) / den,
// one quotient bit per cycle. Expects num < den.
// ----------------------------------------------------------------------------
module klerp_div
    import klerp_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_W_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [TIME_WIDTH-1:0] num,
    input  logic [TIME_WIDTH-1:0] den,
    output klerp_div_stat_t       stat,
    output logic [FRAC_W-1:0]     quot
);

    localparam int CNT_W = $clog2(FRAC_W);

    logic [TIME_WIDTH-1:0] rem_reg;
    logic [TIME_WIDTH-1:0] den_reg;
    logic [FRAC_W-1:0]     quot_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [TIME_WIDTH:0]   rem_sh;
    logic                  fits;

    assign rem_sh = {rem_reg, 1'b0};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FRAC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? TIME_WIDTH'(rem_sh - {1'b0, den_reg}) : TIME_WIDTH'(rem_sh);
            quot_reg <= {quot_reg[FRAC_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

>>> sim/tb_keyframe_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// tb_keyframe_linear_interpolator_top
// Self-checking bench for the keyframe linear interpolator.
// Key writes and time queries are streamed in from a queue, each query is
// interpolated against a shadow key table in the bench, and every result
// transaction is compared field by field in order. Phases step key_count
// through its extremes and vary the idle and stall rates on both streams.
// ----------------------------------------------------------------------------
module tb_keyframe_linear_interpolator_top
    import klerp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKEYS        = 16;
    localparam int VW           = 24;
    localparam int TW           = 24;
    localparam int IN_TDATA_W   = 128;
    localparam int OUT_TDATA_W  = 80;
    localparam int TIME_MAX     = 24'hFFFFFF;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct {
        logic          req;
        logic [3:0]    slot;
        logic [TW-1:0] ktime;
        logic [VW-1:0] kx;
        logic [VW-1:0] ky;
        logic [VW-1:0] kz;
        logic [TW-1:0] qtime;
    } key_req_t;

    typedef struct {
        logic [VW-1:0]    x;
        logic [VW-1:0]    y;
        logic [VW-1:0]    z;
        logic [SEG_W-1:0] seg;
    } interp_res_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   key_count_we = 1'b0;
    logic [COUNT_W-1:0]     key_count_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    key_req_t    pending_reqs[$];
    interp_res_t expected_interp[$];

    logic [TW-1:0]        tbl_time[NKEYS];
    logic signed [VW-1:0] tbl_val[NKEYS][3];
    int                   cfg_count = 1;
    logic [TW-1:0]        gen_time[NKEYS];

    int send_idle  = 0;
    int recv_stall = 0;
    int err_cnt    = 0;
    int cycle_cnt  = 0;

    keyframe_linear_interpolator_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .key_count_we    (key_count_we),
        .key_count_wdata (key_count_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic interp_res_t interpolate_query(logic [TW-1:0] qt);
        int          n;
        int          seg;
        int          c;
        longint      fac;
        longint      s;
        longint      d;
        longint      r;
        interp_res_t res;
        n = cfg_count;
        if (n < 1)
            n = 1;
        if (n > NKEYS)
            n = NKEYS;
        if (n == 1)
        begin
            res.x   = tbl_val[0][0];
            res.y   = tbl_val[0][1];
            res.z   = tbl_val[0][2];
            res.seg = '0;
            return res;
        end
        seg = 0;
        while (seg + 1 < n && !(qt < tbl_time[seg + 1]))
            seg++;
        if (seg + 1 >= n)
        begin
            res.x   = tbl_val[n - 1][0];
            res.y   = tbl_val[n - 1][1];
            res.z   = tbl_val[n - 1][2];
            res.seg = SEG_W'(n - 2);
            return res;
        end
        if (tbl_time[seg + 1] <= tbl_time[seg] || qt <= tbl_time[seg])
            fac = 0;
        else
            fac = (longint'(qt - tbl_time[seg]) << FRAC_W)
                  / longint'(tbl_time[seg + 1] - tbl_time[seg]);
        if (fac > (1 << FRAC_W))
            fac = 1 << FRAC_W;
        for (c = 0; c < 3; c++)
        begin
            s = tbl_val[seg][c];
            d = longint'(tbl_val[seg + 1][c]) - s;
            r = s + ((d * fac + ROUND_HALF) >>> FRAC_W);
            case (c)
                0: res.x = r[VW-1:0];
                1: res.y = r[VW-1:0];
                default: res.z = r[VW-1:0];
            endcase
        end
        res.seg = SEG_W'(seg);
        return res;
    endfunction

    task automatic apply_transaction(key_req_t it);
        if (it.req == REQ_WRITE)
        begin
            tbl_time[it.slot]   = it.ktime;
            tbl_val[it.slot][0] = it.kx;
            tbl_val[it.slot][1] = it.ky;
            tbl_val[it.slot][2] = it.kz;
        end
        else
            expected_interp.insert(expected_interp.size(), interpolate_query(it.qtime));
    endtask

    // driver
    always @(posedge clk)
    begin : drive_proc
        key_req_t cur;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                apply_transaction(cur);
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    cur = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur.req;
                    s_tdata  <= {4'b0, cur.qtime, cur.kz, cur.ky, cur.kx, cur.ktime,
                                 cur.slot};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [VW-1:0] exp_v, logic [VW-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // monitor
    always @(posedge clk)
    begin : monitor_proc
        interp_res_t exp_r;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_interp.size() == 0)
                begin
                    $display("%0t: unexpected result expected none actual %h", $time, m_tdata);
                    err_cnt++;
                end
                else
                begin
                    exp_r = expected_interp.pop_front();
                    check_field("out_x", exp_r.x, m_tdata[23:0]);
                    check_field("out_y", exp_r.y, m_tdata[47:24]);
                    check_field("out_z", exp_r.z, m_tdata[71:48]);
                    check_field("segment_index", VW'(exp_r.seg), VW'(m_tdata[75:72]));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb_keyframe_linear_interpolator_top failed");
            $finish;
        end
    end

    function automatic logic [VW-1:0] rand_val(bit wide);
        if (wide)
            return VW'($urandom);
        return VW'(int'($urandom_range(0, 8191)) - 4096);
    endfunction

    task automatic push_write(int slot, logic [TW-1:0] t, logic [VW-1:0] x,
                              logic [VW-1:0] y, logic [VW-1:0] z);
        key_req_t it;
        it.req   = REQ_WRITE;
        it.slot  = slot[3:0];
        it.ktime = t;
        it.kx    = x;
        it.ky    = y;
        it.kz    = z;
        it.qtime = TW'($urandom);
        gen_time[slot] = t;
        pending_reqs.insert(pending_reqs.size(), it);
    endtask

    task automatic push_query(logic [TW-1:0] q);
        key_req_t it;
        it.req   = REQ_QUERY;
        it.slot  = 4'($urandom);
        it.ktime = TW'($urandom);
        it.kx    = VW'($urandom);
        it.ky    = VW'($urandom);
        it.kz    = VW'($urandom);
        it.qtime = q;
        pending_reqs.insert(pending_reqs.size(), it);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_tvalid || expected_interp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_interp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_key_count(int v);
        @(posedge clk);
        key_count_we    <= 1'b1;
        key_count_wdata <= COUNT_W'(v);
        cfg_count = v;
        @(posedge clk);
        key_count_we    <= 1'b0;
    endtask

    // build a fresh track over slots 0..n-1
    task automatic write_track(int n);
        int          mode;
        int unsigned t;
        int unsigned step_max;
        bit          wide;
        int          i;
        mode = $urandom_range(0, 3);
        wide = $urandom_range(0, 3) != 0;
        case (mode)
            0: step_max = 3;
            1: step_max = 255;
            default: step_max = TIME_MAX / NKEYS;
        endcase
        t = (mode == 2) ? $urandom_range(0, 255) : $urandom_range(0, 65535);
        for (i = 0; i < n; i++)
        begin
            if (mode == 3)
                t = $urandom_range(0, TIME_MAX);
            push_write(i, TW'(t), rand_val(wide), rand_val(wide), rand_val(wide));
            t = t + $urandom_range(0, step_max);
            if (t > TIME_MAX)
                t = TIME_MAX;
        end
    endtask

    function automatic logic [TW-1:0] near_time(int n);
        int unsigned lo;
        int unsigned hi;
        int          r;
        r = $urandom_range(0, n - 1);
        case ($urandom_range(0, 4))
            0: return gen_time[r];
            1: return (gen_time[r] == 0) ? gen_time[r] : gen_time[r] - 1'b1;
            2: return (gen_time[r] == TIME_MAX) ? gen_time[r] : gen_time[r] + 1'b1;
            default:
            begin
                lo = (gen_time[0] > 64) ? gen_time[0] - 64 : 0;
                hi = gen_time[n - 1] + 64;
                if (hi > TIME_MAX)
                    hi = TIME_MAX;
                return TW'($urandom_range(lo, hi));
            end
        endcase
    endfunction

    initial
    begin : stimulus
        int i;
        int ph;
        int kc;
        int n;
        int sent;
        int cnt;
        int slot;
        int kc_list[6] = '{0, 31, 17, 2, 1, 16};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // key table: extremes, a repeated time and one at the top of the range
        for (i = 0; i < NKEYS; i++)
            push_write(i, (i == 15) ? TW'(TIME_MAX) : (i == 3) ? TW'(24'h300)
                                                    : TW'((i + 1) * 24'h100),
                       (i % 2) ? 24'h800000 : 24'h7FFFFF,
                       (i % 2) ? 24'h7FFFFF : 24'h800000,
                       VW'(i * 24'h1000));
        push_query('0);
        wait_drained();
        write_key_count(NKEYS);
        push_query('0);
        push_query(24'h100);
        push_query(24'h180);
        push_query(24'h300);
        push_query(24'hFFFFFE);
        push_query(24'hFFFFFF);
        wait_drained();

        sent = 0;
        ph   = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (ph < 6)
                kc = kc_list[ph];
            else if ($urandom_range(0, 9) == 0)
                kc = kc_list[$urandom_range(0, 5)];
            else
                kc = $urandom_range(1, NKEYS);
            n = (kc < 1) ? 1 : (kc > NKEYS) ? NKEYS : kc;
            write_key_count(kc);
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 47; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 47; end
                default: begin send_idle = 36; recv_stall = 36; end
            endcase
            if ($urandom_range(0, 2) != 0)
            begin
                write_track(n);
                sent += n;
            end
            cnt = $urandom_range(20, 50);
            for (i = 0; i < cnt; i++)
            begin
                case ($urandom_range(0, 19))
                    0, 1:
                    begin
                        slot = $urandom_range(0, NKEYS - 1);
                        push_write(slot, ($urandom_range(0, 3) == 0) ? TW'($urandom)
                                   : TW'(gen_time[slot] + $urandom_range(0, 16) - 8),
                                   rand_val(1'b1), rand_val(1'b1), rand_val(1'b0));
                    end
                    2, 3:
                        push_query(TW'($urandom));
                    default:
                        push_query(near_time(n));
                endcase
            end
            sent += cnt;
            ph++;
            wait_drained();
        end

        if (err_cnt == 0)
            $display("tb_keyframe_linear_interpolator_top passed");
        else
            $display("tb_keyframe_linear_interpolator_top failed");
        $finish;
    end

endmodule

>>> files.f
hdl/klerp_pkg.sv
hdl/klerp_store.sv
hdl/klerp_div.sv
hdl/keyframe_linear_interpolator_top.sv
sim/tb_keyframe_linear_interpolator_top.sv
